>>> sv/kvs_pkg.sv
`timescale 1ns / 1ps
package kvs_pkg;
   localparam int TIME_W = 32;
   localparam int VAL_W  = 32;
   localparam int FRAC_W = 17;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // front-to-back queue entry
   typedef struct packed {
      op_type            op;
      logic [5:0]        key_index;
      logic [TIME_W-1:0] key_time;
      logic [VAL_W-1:0]  key_x;
      logic [VAL_W-1:0]  key_y;
      logic [VAL_W-1:0]  key_z;
      logic [TIME_W-1:0] query_time;
   } cmd_type;

   typedef struct packed {
      logic [VAL_W-1:0] x;
      logic [VAL_W-1:0] y;
      logic [VAL_W-1:0] z;
   } vec_type;
endpackage

>>> sv/kvs_front.sv
`timescale 1ns / 1ps
// two-entry queue of registered commands toward the back end
module kvs_front
   import kvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign out_valid = (cnt_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign out_cmd   = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = pop ? ~rd_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
      if (push) begin
         q_ff[rd_ff ^ cnt_ff[0]] <= in_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_pop_then_rd: assert property (@(posedge clock) disable iff (reset)
      pop |=> rd_ff != $past(rd_ff)) else $error("read pointer stuck");
`endif
endmodule

>>> sv/kvs_div.sv
`timescale 1ns / 1ps
// restoring divider: quotient of (num << 16) / den, one bit per cycle
module kvs_div
   import kvs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] num,
   input  logic [TIME_W-1:0] den,
   output logic              done,
   output logic [FRAC_W-1:0] quot
);
   localparam int STEPS = 49;
   logic [48:0]       dvd_ff, dvd_in;
   logic [TIME_W:0]   rem_ff, rem_in;
   logic [TIME_W-1:0] den_ff;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [TIME_W+1:0] trial;
   logic [TIME_W:0]   shifted;

   assign quot = dvd_ff[FRAC_W-1:0];
   assign done = busy_ff && (cnt_ff == 6'd0);

   always_comb begin
      shifted = {rem_ff[TIME_W-1:0], dvd_ff[48]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvd_in  = {1'b0, num, 16'd0};
         rem_in  = '0;
         cnt_in  = 6'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff != 6'd0) begin
         if (!trial[TIME_W+1]) begin
            rem_in = trial[TIME_W:0];
            dvd_in = {dvd_ff[47:0], 1'b1};
         end else begin
            rem_in = shifted;
            dvd_in = {dvd_ff[47:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (start) den_ff <= den;
   end
endmodule

>>> sv/kvs_back.sv
`timescale 1ns / 1ps
// key table, segment search, divide and blend, result register
module kvs_back
   import kvs_pkg::*;
#(
   parameter int MAX_KEYS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic [6:0] key_count,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output vec_type rsp
);
   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_RD0   = 8'b00000010,
      S_CHK0  = 8'b00000100,
      S_SRCH  = 8'b00001000,
      S_TEST  = 8'b00010000,
      S_DIV   = 8'b00100000,
      S_BLEND = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   logic [TIME_W-1:0] tmem [MAX_KEYS];
   vec_type           vmem [MAX_KEYS];

   state_type         st_ff, st_in;
   cmd_type           cur_ff;
   logic [AW-1:0]     ra_ff, ra_in;
   logic [TIME_W-1:0] trd_ff;
   vec_type           vrd_ff;
   logic [TIME_W-1:0] t0_ff;
   vec_type           v0_ff;
   logic [AW:0]       n_ff;
   logic [AW-1:0]     i_ff, i_in;
   logic [1:0]        comp_ff;
   vec_type           res_ff;
   logic              rv_ff;
   logic [FRAC_W-1:0] f_ff;
   logic              div_start, div_done;
   logic [FRAC_W-1:0] div_q;
   logic [AW:0]       n_clip;
   logic [31:0]       a_s, b_s;
   logic signed [VAL_W:0]   diff;
   logic signed [50:0]      prod;
   logic signed [50:0]      rnd;
   logic signed [VAL_W+1:0] sum;
   logic [VAL_W-1:0]        sat;

   assign cmd_ready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp       = res_ff;

   always_comb begin
      if (key_count == 7'd0) n_clip = (AW+1)'(1);
      else if ({25'd0, key_count} > 32'(MAX_KEYS)) n_clip = (AW+1)'(MAX_KEYS);
      else n_clip = (AW+1)'(key_count);
   end

   kvs_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num   (cur_ff.query_time - t0_ff), .den (trd_ff - t0_ff),
      .done  (div_done), .quot (div_q)
   );

   always_comb begin
      case (comp_ff)
         2'd0:    begin a_s = v0_ff.x; b_s = vrd_ff.x; end
         2'd1:    begin a_s = v0_ff.y; b_s = vrd_ff.y; end
         default: begin a_s = v0_ff.z; b_s = vrd_ff.z; end
      endcase
      diff = $signed({b_s[31], b_s}) - $signed({a_s[31], a_s});
      prod = 51'(diff) * $signed({34'd0, f_ff});
      rnd  = (prod + 51'sd32768) >>> 16;
      sum  = $signed({{2{a_s[31]}}, a_s}) + 34'(rnd);
      if (sum > 34'sd2147483647) sat = 32'h7fffffff;
      else if (sum < -34'sd2147483648) sat = 32'h80000000;
      else sat = sum[31:0];
   end

   always_comb begin
      st_in     = st_ff;
      ra_in     = ra_ff;
      i_in      = i_ff;
      div_start = 1'b0;
      case (st_ff)
         S_IDLE: if (cmd_valid && cmd_ready) begin
            if (cmd.op == OP_SAMPLE) begin
               ra_in = '0;
               st_in = S_RD0;
            end
         end
         S_RD0: st_in = S_CHK0;
         S_CHK0: begin
            if (n_ff == (AW+1)'(1) || cur_ff.query_time <= trd_ff) begin
               st_in = S_OUT;
            end else begin
               i_in  = '0;
               ra_in = AW'(1);
               st_in = S_SRCH;
            end
         end
         S_SRCH: st_in = S_TEST;
         S_TEST: begin
            // t0 holds key i, trd holds key i+1
            if (t0_ff <= cur_ff.query_time && cur_ff.query_time <= trd_ff) begin
               st_in = S_DIV;
               div_start = (trd_ff != t0_ff);
            end else if ({1'b0, i_ff} + (AW+1)'(2) >= n_ff) begin
               st_in = S_OUT;
            end else begin
               i_in  = i_ff + AW'(1);
               ra_in = ra_ff + AW'(1);
               st_in = S_SRCH;
            end
         end
         S_DIV: if (div_done || trd_ff == t0_ff) st_in = S_BLEND;
         S_BLEND: if (comp_ff == 2'd2) st_in = S_IDLE;
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         rv_ff   <= 1'b0;
         comp_ff <= 2'd0;
      end else begin
         st_ff <= st_in;
         if (rsp_valid && rsp_ready) rv_ff <= 1'b0;
         if (st_ff == S_OUT) rv_ff <= 1'b1;
         if (st_ff == S_BLEND && comp_ff == 2'd2) rv_ff <= 1'b1;
         if (st_ff == S_BLEND) comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
      end
      ra_ff <= ra_in;
      i_ff  <= i_in;
      trd_ff <= tmem[ra_in];
      vrd_ff <= vmem[ra_in];
      if (st_ff == S_IDLE && cmd_valid && cmd_ready) begin
         cur_ff <= cmd;
         n_ff   <= n_clip;
         if (cmd.op == OP_WRITE && {26'd0, cmd.key_index} < 32'(MAX_KEYS)) begin
            tmem[AW'(cmd.key_index)] <= cmd.key_time;
            vmem[AW'(cmd.key_index)] <= '{x: cmd.key_x, y: cmd.key_y, z: cmd.key_z};
         end
      end
      if (st_ff == S_CHK0 || st_ff == S_TEST && st_in == S_SRCH) begin
         t0_ff <= trd_ff;
         v0_ff <= vrd_ff;
      end
      if (st_ff == S_CHK0 && st_in == S_OUT) res_ff <= vrd_ff;
      if (st_ff == S_TEST && st_in == S_OUT) res_ff <= vrd_ff;
      if (st_ff == S_DIV && st_in == S_BLEND) f_ff <= (trd_ff == t0_ff) ? '0 : div_q;
      if (st_ff == S_BLEND) begin
         case (comp_ff)
            2'd0:    res_ff.x <= sat;
            2'd1:    res_ff.y <= sat;
            default: res_ff.z <= sat;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(st_ff)) else $error("state not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("result dropped");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !cmd_ready) else $error("accepted with result pending");
`endif
endmodule

>>> sv/keyframe_vector_sampler.sv
`timescale 1ns / 1ps
// channel   dir  fields (low bit up)
// req_      in   tdata: op, key_index, key_time, key_x, key_y, key_z, query_time (+1 pad)
// rsp_      out  tdata: out_x, out_y, out_z
// csr_      in   wdata: key_count
// a keyframe write waits in the queue and reaches the table when the idle back end takes it.
// a sample returns the first key when one key is in use or the query does not pass that key,
// the last key when it runs past the last key after every segment is tested (S_SRCH, S_TEST),
// and a blend otherwise (bit-serial divide, shared multiplier; zero-length: no divide).
// reset is synchronous; the key table is not cleared and must be written before use.
// the two-entry queue keeps taking transfers, until it is full, while the back end works or a result stalls.
module keyframe_vector_sampler
   import kvs_pkg::*;
#(
   parameter int MAX_KEYS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,  // op, key_index, key_time, key_x, key_y, key_z, query_time
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // out_x, out_y, out_z
   input  logic         csr_wen,
   input  logic [6:0]   csr_wdata   // key_count
);
   logic [6:0] cnt_ff;
   cmd_type    in_cmd, q_cmd;
   logic       q_valid, q_ready;
   vec_type    res;

   always_comb begin
      in_cmd.op         = op_type'(req_tdata[0]);
      in_cmd.key_index  = req_tdata[6:1];
      in_cmd.key_time   = req_tdata[38:7];
      in_cmd.key_x      = req_tdata[70:39];
      in_cmd.key_y      = req_tdata[102:71];
      in_cmd.key_z      = req_tdata[134:103];
      in_cmd.query_time = req_tdata[166:135];
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 7'd1;
      else if (csr_wen) cnt_ff <= csr_wdata;
   end

   kvs_front u_front (
      .clock (clock), .reset (reset),
      .in_valid (req_tvalid), .in_ready (req_tready), .in_cmd (in_cmd),
      .out_valid (q_valid), .out_ready (q_ready), .out_cmd (q_cmd)
   );

   kvs_back #(.MAX_KEYS (MAX_KEYS)) u_back (
      .clock (clock), .reset (reset), .key_count (cnt_ff),
      .cmd_valid (q_valid), .cmd_ready (q_ready), .cmd (q_cmd),
      .rsp_valid (rsp_tvalid), .rsp_ready (rsp_tready), .rsp (res)
   );

   assign rsp_tdata = {res.z, res.y, res.x};
endmodule

>>> verif/tb_keyframe_vector_sampler.sv
`timescale 1ns / 1ps
module tb_keyframe_vector_sampler;
   import kvs_pkg::*;

   localparam int  NKEYS       = 64;
   localparam int  SETTLE      = 400;
   localparam longint MAX_CYC  = 1500000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [167:0] req_tdata;   // op, key_index, key_time, key_x, key_y, key_z, query_time, pad
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;   // out_x, out_y, out_z
   logic         csr_wen;
   logic [6:0]   csr_wdata;   // key_count

   keyframe_vector_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   cmd_type     pending_cmds[$];
   vec_type     expected_vecs[$];
   int          errors;
   longint      cycles;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int          hold_request;
   int          hold_left;
   logic        req_moved;

   // predictor copy of the key table and the count register
   logic [31:0] key_tm[NKEYS];
   logic [31:0] key_vx[NKEYS];
   logic [31:0] key_vy[NKEYS];
   logic [31:0] key_vz[NKEYS];
   logic [6:0]  key_count_reg;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      errors++;
      $display("mismatch @%0t: %s", $realtime, msg);
   endtask

   function automatic logic [31:0] lerp_component(logic [31:0] a_bits, logic [31:0] b_bits,
                                                  longint t);
      longint a;
      longint b;
      longint m;
      longint r;
      a = longint'(signed'(a_bits));
      b = longint'(signed'(b_bits));
      m = (b - a) * t + 32768;
      r = a + (m >>> 16);   // arithmetic shift gives the floor
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   function automatic vec_type sample_curve(logic [31:0] q);
      vec_type v;
      int      n;
      logic [31:0] t0;
      logic [31:0] t1;
      longint  frac;
      n = int'(key_count_reg);
      if (n < 1) n = 1;
      if (n > NKEYS) n = NKEYS;
      if (n == 1 || q <= key_tm[0]) begin
         v.x = key_vx[0]; v.y = key_vy[0]; v.z = key_vz[0];
         return v;
      end
      for (int i = 0; i + 1 < n; i++) begin
         t0 = key_tm[i];
         t1 = key_tm[i+1];
         if (t0 <= q && q <= t1) begin
            frac = 0;
            if (t1 != t0)
               frac = longint'((64'(q - t0) << 16) / 64'(t1 - t0));
            v.x = lerp_component(key_vx[i], key_vx[i+1], frac);
            v.y = lerp_component(key_vy[i], key_vy[i+1], frac);
            v.z = lerp_component(key_vz[i], key_vz[i+1], frac);
            return v;
         end
      end
      v.x = key_vx[n-1]; v.y = key_vy[n-1]; v.z = key_vz[n-1];
      return v;
   endfunction

   function automatic logic [167:0] pack_req(cmd_type c);
      return {1'b0, c.query_time, c.key_z, c.key_y, c.key_x, c.key_time, c.key_index, c.op};
   endfunction

   function automatic cmd_type unpack_req(logic [167:0] d);
      cmd_type c;
      c.op         = op_type'(d[0]);
      c.key_index  = d[6:1];
      c.key_time   = d[38:7];
      c.key_x      = d[70:39];
      c.key_y      = d[102:71];
      c.key_z      = d[134:103];
      c.query_time = d[166:135];
      return c;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return $urandom_range(32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   // stimulus model of the table, for choosing queries
   logic [31:0] plan_tm[NKEYS];

   task automatic push_write(int idx, logic [31:0] tm);
      cmd_type c;
      c.op         = OP_WRITE;
      c.key_index  = idx[5:0];
      c.key_time   = tm;
      c.key_x      = rand_value();
      c.key_y      = rand_value();
      c.key_z      = rand_value();
      c.query_time = $urandom;
      plan_tm[idx] = tm;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   task automatic push_sample(logic [31:0] q);
      cmd_type c;
      c.op         = OP_SAMPLE;
      c.key_index  = 6'($urandom);
      c.key_time   = $urandom;
      c.key_x      = $urandom;
      c.key_y      = $urandom;
      c.key_z      = $urandom;
      c.query_time = q;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // ascending times for slots 0..n-1, with zero-length and short segments mixed in
   task automatic load_table(int n, logic [31:0] start, int wide);
      logic [31:0] tm;
      tm = start;
      for (int i = 0; i < n; i++) begin
         push_write(i, tm);
         case ($urandom_range(5))
            0: tm = tm;
            1: tm = tm + $urandom_range(3);
            default: tm = tm + (wide ? $urandom_range(32'h0400_0000) : $urandom_range(32'h0003_0000));
         endcase
         if (tm < plan_tm[i]) tm = 32'hFFFF_FFFF;
      end
   endtask

   function automatic logic [31:0] pick_query(int n);
      int i;
      i = $urandom_range(n - 1);
      case ($urandom_range(6))
         0: return plan_tm[i];
         1: return plan_tm[0] - $urandom_range(2);
         2: return plan_tm[n-1] + $urandom_range(2);
         3: return $urandom;
         default: begin
            if (i + 1 < n && plan_tm[i+1] > plan_tm[i])
               return plan_tm[i] + $urandom_range(plan_tm[i+1] - plan_tm[i]);
            return plan_tm[i];
         end
      endcase
   endfunction

   task automatic wait_idle();
      wait (pending_cmds.size() == 0 && !req_tvalid && expected_vecs.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] v);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   // sender: a new transfer is offered only once the previous one moved
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid = 1'b0;
      end else if (!req_tvalid || req_moved) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  = pack_req(pending_cmds.pop_front());
            req_tvalid = 1'b1;
         end else begin
            req_tvalid = 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end else if (hold_left > 0) begin
         hold_left--;
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_tready = 1'b0;
      else if (hold_left > 0)
         rsp_tready = 1'b0;
      else
         rsp_tready = ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cmd_type c;
      vec_type want;
      vec_type got;
      req_moved = req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (csr_wen)
            key_count_reg = csr_wdata;
         if (req_tvalid && req_tready) begin
            c = unpack_req(req_tdata);
            if (c.op == OP_WRITE) begin
               key_tm[c.key_index] = c.key_time;
               key_vx[c.key_index] = c.key_x;
               key_vy[c.key_index] = c.key_y;
               key_vz[c.key_index] = c.key_z;
            end else begin
               expected_vecs.insert(expected_vecs.size(), sample_curve(c.query_time));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.x = rsp_tdata[31:0];
            got.y = rsp_tdata[63:32];
            got.z = rsp_tdata[95:64];
            if (expected_vecs.size() == 0) begin
               report($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = expected_vecs.pop_front();
               if (got.x !== want.x)
                  report($sformatf("out_x got %h want %h", got.x, want.x));
               if (got.y !== want.y)
                  report($sformatf("out_y got %h want %h", got.y, want.y));
               if (got.z !== want.z)
                  report($sformatf("out_z got %h want %h", got.z, want.z));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYC) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   logic [6:0] count_plan[16] = '{7'd1, 7'd64, 7'd2, 7'd0, 7'd127, 7'd5, 7'd3, 7'd64,
                                  7'd17, 7'd2, 7'd40, 7'd1, 7'd9, 7'd65, 7'd64, 7'd6};

   initial begin
      int n;
      errors        = 0;
      cycles        = 0;
      hold_request  = 0;
      hold_left     = 0;
      req_moved     = 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_wen       = 1'b0;
      csr_wdata     = '0;
      key_count_reg = 7'd1;
      reset         = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every slot gets written before anything is sampled
      load_table(NKEYS, 32'd0, 1);
      push_sample(32'd0);
      push_sample(32'hFFFF_FFFF);
      wait_idle();
      write_count(7'd64);
      // directed: extremes of time, exact key hits, the top end of the table
      push_sample(32'd0);
      push_sample(32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++)
         push_sample(plan_tm[$urandom_range(NKEYS - 1)]);
      push_write(0, 32'd100);
      push_write(1, 32'd100);        // zero-length segment
      push_write(2, 32'hFFFF_FFFF);
      push_sample(32'd100);
      push_sample(32'd101);
      push_sample(32'hFFFF_FFFE);
      wait_idle();

      for (int ph = 0; ph < 16; ph++) begin
         write_count(count_plan[ph]);
         n = int'(count_plan[ph]);
         if (n < 1) n = 1;
         if (n > NKEYS) n = NKEYS;
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         if (ph == 7) begin
            send_idle_pct = 0;
            stall_pct     = 0;
            hold_request  = 3000;
         end
         load_table(n, (ph % 3 == 0) ? $urandom : $urandom_range(32'h0010_0000), ph % 2);
         for (int k = 0; k < 25; k++) begin
            // a few rewrites out of order as noise
            if ($urandom_range(9) == 0)
               push_write($urandom_range(n - 1), $urandom);
            push_sample(pick_query(n));
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
